// ===== sv/best_fit_partition_allocator_assert.svh =====
// Assertion macros used by the checker file of the best-fit allocator.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef BEST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH

// An implication checked at every rising clock edge outside reset.
`define BFPA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define BFPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bfpa_pkg.sv =====
// Package of the best-fit partition allocator: defaults, operation codes,
// and the microcode program of the request and load sequencer. No dependencies.
package bfpa_pkg;

	// Default sizes of the partition table.
	localparam int PARTITIONS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 16;

	// Widths of the fixed port fields.
	localparam int CFG_W   = 5;
	localparam int PIDX_W  = 4;
	localparam int SIZEP_W = 16;
	localparam int SUM_W   = 32;

	// Reset value of the partitions-in-use register.
	localparam logic [CFG_W-1:0] PIU_RESET = 5'd16;

	// Item operation codes.
	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_REQUEST = 1'b1
	} op_t;

	// Microcode step addresses.
	localparam int STEP_W = 2;
	typedef logic [STEP_W-1:0] step_t;
	localparam step_t STEP_IDLE   = 2'd0;
	localparam step_t STEP_SCAN   = 2'd1;
	localparam step_t STEP_FINISH = 2'd2;
	localparam step_t STEP_LOAD   = 2'd3;

	// Sequencing conditions of a control word.
	typedef enum logic [1:0] {
		COND_NEXT = 2'd0,
		COND_GOTO = 2'd1,
		COND_IDLE = 2'd2,
		COND_SCAN = 2'd3
	} cond_t;

	// One control word of the program.
	typedef struct packed {
		logic  init;
		logic  scan;
		logic  finish;
		logic  load;
		cond_t cond;
		step_t target;
	} ucode_t;

	// The program: wait for an item, scan the table, settle the grant, or write a size.
	function automatic ucode_t ucode_rom(input step_t pc);
		ucode_t uc;
		uc = '{init: 1'b0, scan: 1'b0, finish: 1'b0, load: 1'b0,
			cond: COND_GOTO, target: STEP_IDLE};
		case (pc)
			STEP_IDLE: begin
				uc.init   = 1'b1;
				uc.cond   = COND_IDLE;
				uc.target = STEP_LOAD;
			end
			STEP_SCAN: begin
				uc.scan   = 1'b1;
				uc.cond   = COND_SCAN;
				uc.target = STEP_SCAN;
			end
			STEP_FINISH: begin
				uc.finish = 1'b1;
				uc.cond   = COND_GOTO;
				uc.target = STEP_IDLE;
			end
			STEP_LOAD: begin
				uc.load   = 1'b1;
				uc.cond   = COND_GOTO;
				uc.target = STEP_IDLE;
			end
			default: begin
				uc.cond   = COND_GOTO;
				uc.target = STEP_IDLE;
			end
		endcase
		return uc;
	endfunction

endpackage

// ===== sv/bfpa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the partition size table.
module bfpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/best_fit_partition_allocator.sv =====
// Top level of the best-fit partition allocator: microcoded sequencer and datapath.
// Depends on bfpa_pkg and bfpa_ram.
//
// Usage: an item is taken when start is high and busy is low. operation selects a
// load (write partition_index's size, mark it loaded and free) or a request (find the
// smallest loaded, free partition below partitions_in_use that holds size_value,
// lowest index on a tie). Each item gives one result beat: done is high for exactly
// one cycle with granted, chosen_partition, leftover and both running totals; the
// receiver cannot stall, so the beat is gone after that cycle.
// A load passes through the LOAD step and a request through SCAN and then FINISH; the
// beat is registered out of LOAD or FINISH. SCAN walks N entries, where N is
// partitions_in_use clamped to PARTITIONS, and reads one table entry per cycle
// through the size RAM's single read port. busy stays high until the program is back
// at IDLE, and the next item can be taken in the same cycle that carries the previous
// result beat.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes partitions_in_use;
// it is always ready and is meant to be written while no item is in flight.
// Reset (arst_n low) clears all loaded and taken marks, both totals, and sets
// partitions_in_use to 16. Sizes are not cleared; a partition is unused until loaded.
module best_fit_partition_allocator #(
	parameter int PARTITIONS = bfpa_pkg::PARTITIONS_DEF,
	parameter int SIZE_BITS  = bfpa_pkg::SIZE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              operation,
	input  logic [bfpa_pkg::PIDX_W-1:0]       partition_index,
	input  logic [bfpa_pkg::SIZEP_W-1:0]      size_value,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bfpa_pkg::CFG_W-1:0]        cfg_data,
	output logic                              done,
	output logic                              granted,
	output logic [bfpa_pkg::PIDX_W-1:0]       chosen_partition,
	output logic [bfpa_pkg::SIZEP_W-1:0]      leftover,
	output logic [bfpa_pkg::SUM_W-1:0]        internal_total,
	output logic [bfpa_pkg::SUM_W-1:0]        external_total
);

	localparam int IDX_W = $clog2(PARTITIONS);
	localparam int CNT_W = $clog2(PARTITIONS + 1);

	// Sequencer.
	bfpa_pkg::step_t  pc_q;
	bfpa_pkg::step_t  pc_d;
	bfpa_pkg::ucode_t uc;

	// Item latches.
	logic                          op_q;
	logic [bfpa_pkg::PIDX_W-1:0]   idx_q;
	logic [SIZE_BITS-1:0]          size_q;

	// Scan datapath.
	logic [CNT_W-1:0]     addr_q;
	logic [CNT_W-1:0]     limit;
	logic                 rd_en;
	logic                 cmp_v_s1;
	logic [IDX_W-1:0]     cmp_idx_s1;
	logic [SIZE_BITS-1:0] rdata;
	logic                 hit;
	logic                 found_q;
	logic [IDX_W-1:0]     best_q;
	logic [SIZE_BITS-1:0] best_size_q;

	// Partition marks and configuration.
	logic [PARTITIONS-1:0]         loaded_q;
	logic [PARTITIONS-1:0]         taken_q;
	logic [bfpa_pkg::CFG_W-1:0]    piu_q;
	logic                          load_ok;
	logic                          accept;

	// Totals and result.
	logic [SIZE_BITS-1:0]          left;
	logic [bfpa_pkg::SUM_W:0]      int_add;
	logic [bfpa_pkg::SUM_W:0]      ext_add;
	logic [bfpa_pkg::SUM_W-1:0]    int_sum_q;
	logic [bfpa_pkg::SUM_W-1:0]    ext_sum_q;
	logic                          done_q;
	logic                          granted_q;
	logic [bfpa_pkg::PIDX_W-1:0]   chosen_q;
	logic [bfpa_pkg::SIZEP_W-1:0]  leftover_q;

	// Current control word and handshake.
	assign uc        = bfpa_pkg::ucode_rom(pc_q);
	assign busy      = (pc_q != bfpa_pkg::STEP_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// Search count clamped to the table size.
	always_comb begin
		if (32'(piu_q) > PARTITIONS) begin
			limit = CNT_W'(PARTITIONS);
		end else begin
			limit = CNT_W'(piu_q);
		end
	end

	// Next step of the program.
	always_comb begin
		case (uc.cond)
			bfpa_pkg::COND_NEXT: pc_d = bfpa_pkg::step_t'(pc_q + 1'b1);
			bfpa_pkg::COND_GOTO: pc_d = uc.target;
			bfpa_pkg::COND_IDLE: begin
				if (!start) begin
					pc_d = pc_q;
				end else if (operation == bfpa_pkg::OP_LOAD) begin
					pc_d = uc.target;
				end else begin
					pc_d = bfpa_pkg::step_t'(pc_q + 1'b1);
				end
			end
			bfpa_pkg::COND_SCAN: begin
				if (addr_q < limit) begin
					pc_d = uc.target;
				end else begin
					pc_d = bfpa_pkg::step_t'(pc_q + 1'b1);
				end
			end
			default: pc_d = bfpa_pkg::STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= bfpa_pkg::STEP_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	// Latch the item when it is accepted.
	always_ff @(posedge clk) begin
		if (uc.init && accept) begin
			op_q   <= operation;
			idx_q  <= partition_index;
			size_q <= SIZE_BITS'(size_value);
		end
	end

	assign load_ok = (32'(idx_q) < PARTITIONS);

	// Partition size table.
	assign rd_en = uc.scan && (addr_q < limit);

	bfpa_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (PARTITIONS)
	) u_size_ram (
		.clk   (clk),
		.we    (uc.load && load_ok),
		.waddr (IDX_W'(idx_q)),
		.wdata (size_q),
		.re    (rd_en),
		.raddr (addr_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	// Scan address and compare stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q   <= '0;
			cmp_v_s1 <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			cmp_v_s1 <= rd_en;
			if (uc.init) begin
				addr_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (rd_en) begin
					addr_q <= CNT_W'(addr_q + 1'b1);
				end
				if (hit) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// A candidate wins when it is usable, fits, and beats the best so far.
	assign hit = cmp_v_s1 && loaded_q[cmp_idx_s1] && !taken_q[cmp_idx_s1] &&
		(rdata >= size_q) && (!found_q || (rdata < best_size_q));

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= addr_q[IDX_W-1:0];
		if (hit) begin
			best_q      <= cmp_idx_s1;
			best_size_q <= rdata;
		end
	end

	// Saturating running totals.
	assign left    = best_size_q - size_q;
	assign int_add = {1'b0, int_sum_q} + (bfpa_pkg::SUM_W + 1)'(left);
	assign ext_add = {1'b0, ext_sum_q} + (bfpa_pkg::SUM_W + 1)'(size_q);

	// Marks, totals, configuration and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q  <= '0;
			taken_q   <= '0;
			int_sum_q <= '0;
			ext_sum_q <= '0;
			piu_q     <= bfpa_pkg::PIU_RESET;
			done_q    <= 1'b0;
		end else begin
			done_q <= uc.finish || uc.load;
			if (cfg_valid && cfg_ready) begin
				piu_q <= cfg_data;
			end
			if (uc.load && load_ok) begin
				loaded_q[IDX_W'(idx_q)] <= 1'b1;
				taken_q[IDX_W'(idx_q)]  <= 1'b0;
			end
			if (uc.finish) begin
				if (found_q) begin
					taken_q[best_q] <= 1'b1;
					int_sum_q <= int_add[bfpa_pkg::SUM_W] ? '1 : int_add[bfpa_pkg::SUM_W-1:0];
				end else begin
					ext_sum_q <= ext_add[bfpa_pkg::SUM_W] ? '1 : ext_add[bfpa_pkg::SUM_W-1:0];
				end
			end
		end
	end

	// Result fields of the beat.
	always_ff @(posedge clk) begin
		if (uc.finish && found_q && (op_q == bfpa_pkg::OP_REQUEST)) begin
			granted_q  <= 1'b1;
			chosen_q   <= (bfpa_pkg::PIDX_W)'(best_q);
			leftover_q <= (bfpa_pkg::SIZEP_W)'(left);
		end else if (uc.finish || uc.load) begin
			granted_q  <= 1'b0;
			chosen_q   <= '0;
			leftover_q <= '0;
		end
	end

	assign done             = done_q;
	assign granted          = granted_q;
	assign chosen_partition = chosen_q;
	assign leftover         = leftover_q;
	assign internal_total   = int_sum_q;
	assign external_total   = ext_sum_q;

endmodule

// ===== sv/bfpa_checker.sv =====
// Port-level checker of the best-fit partition allocator, bound to the top level.
// Depends on best_fit_partition_allocator_assert.svh for its assertion macros.
`include "best_fit_partition_allocator_assert.svh"

module bfpa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        operation,
	input logic [3:0]  partition_index,
	input logic [15:0] size_value,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [4:0]  cfg_data,
	input logic        done,
	input logic        granted,
	input logic [3:0]  chosen_partition,
	input logic [15:0] leftover,
	input logic [31:0] internal_total,
	input logic [31:0] external_total
);

	// No result beat can come in the cycle right after an item is taken.
	`BFPA_ASSERT_NEXT(a_no_early_beat, start && !busy, !done, "result beat too early")

	// A result beat appears only once the block is ready for the next item.
	`BFPA_ASSERT_IMPL(a_beat_idle, done, !busy, "result beat while busy")

	// A beat without a grant carries zero index and zero leftover.
	`BFPA_ASSERT_IMPL(a_fail_zero, done && !granted,
		(chosen_partition == 4'd0) && (leftover == 16'd0), "ungranted beat not zero")

	// Both running totals never decrease.
	`BFPA_ASSERT_NEXT(a_totals_grow, 1'b1,
		(internal_total >= $past(internal_total)) && (external_total >= $past(external_total)),
		"running total decreased")

endmodule

bind best_fit_partition_allocator bfpa_checker u_bfpa_checker (.*);

// ===== tb/best_fit_partition_allocator_test.sv =====
// Self-checking testbench for the best-fit partition allocator: directed and random
// load and request beats, checked field by field against a behavioral predictor.
// Depends on bfpa_pkg and the best_fit_partition_allocator RTL.
module best_fit_partition_allocator_test;

	// Field widths and table size from the package.
	localparam int PIDX_W         = bfpa_pkg::PIDX_W;
	localparam int SIZEP_W        = bfpa_pkg::SIZEP_W;
	localparam int SUM_W          = bfpa_pkg::SUM_W;
	localparam int CFG_W          = bfpa_pkg::CFG_W;
	localparam int PARTITIONS_DEF = bfpa_pkg::PARTITIONS_DEF;

	// One input beat of the command port.
	typedef struct {
		bfpa_pkg::op_t        operation;
		logic [PIDX_W-1:0]    part;
		logic [SIZEP_W-1:0]   size;
	} alloc_item_t;

	// One result beat.
	typedef struct {
		logic                 granted;
		logic [PIDX_W-1:0]    chosen;
		logic [SIZEP_W-1:0]   leftover;
		logic [SUM_W-1:0]     internal_total;
		logic [SUM_W-1:0]     external_total;
	} alloc_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 operation = 1'b0;
	logic [PIDX_W-1:0]    partition_index = '0;
	logic [SIZEP_W-1:0]   size_value = '0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 done;
	logic                 granted;
	logic [PIDX_W-1:0]    chosen_partition;
	logic [SIZEP_W-1:0]   leftover;
	logic [SUM_W-1:0]     internal_total;
	logic [SUM_W-1:0]     external_total;

	// Mirror of the allocator state.
	logic [SIZEP_W-1:0]   mirror_size [PARTITIONS_DEF];
	bit                   mirror_loaded [PARTITIONS_DEF];
	bit                   mirror_taken [PARTITIONS_DEF];
	logic [SUM_W-1:0]     mirror_internal = '0;
	logic [SUM_W-1:0]     mirror_external = '0;
	logic [CFG_W-1:0]     mirror_count = bfpa_pkg::PIU_RESET;

	// Beats waiting to be sent and results waiting to arrive.
	alloc_item_t          pending_items [$];
	alloc_beat_t          predicted_beats [$];
	alloc_item_t          cur_item;
	alloc_beat_t          want;

	int                   queued_count = 0;
	int                   accepted_count = 0;
	int                   beat_count = 0;
	int                   fail_count = 0;
	int                   load_count = 0;
	int                   grant_count = 0;
	int                   refuse_count = 0;
	int                   burst_left = 0;
	int                   gap_left = 0;

	// Partition sizes of the directed fill: three-way tie at 500, both size extremes.
	logic [SIZEP_W-1:0]   fill_sizes [PARTITIONS_DEF] = '{
		16'd900, 16'd65535, 16'd800, 16'd500, 16'd0, 16'd1200, 16'd300, 16'd500,
		16'd42, 16'd7000, 16'd500, 16'd65534, 16'd2, 16'd3000, 16'd650, 16'd1};

	best_fit_partition_allocator uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.operation        (operation),
		.partition_index  (partition_index),
		.size_value       (size_value),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.done             (done),
		.granted          (granted),
		.chosen_partition (chosen_partition),
		.leftover         (leftover),
		.internal_total   (internal_total),
		.external_total   (external_total)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Running totals stop at the top of their range.
	function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] acc,
			input logic [SIZEP_W-1:0] addend);
		logic [SUM_W:0] wide;
		wide = {1'b0, acc} + addend;
		return wide[SUM_W] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
	endfunction

	// Applies one accepted beat to the mirror and returns the result it should produce.
	function automatic alloc_beat_t predict_alloc(input alloc_item_t it);
		alloc_beat_t r;
		int lim;
		int j;
		int best;
		bit found;
		r = '{granted: 1'b0, chosen: '0, leftover: '0,
			internal_total: '0, external_total: '0};
		found = 1'b0;
		best = 0;
		if (it.operation == bfpa_pkg::OP_LOAD) begin
			mirror_size[it.part] = it.size;
			mirror_loaded[it.part] = 1'b1;
			mirror_taken[it.part] = 1'b0;
			load_count++;
		end else begin
			lim = (mirror_count > PARTITIONS_DEF) ? PARTITIONS_DEF : mirror_count;
			for (j = 0; j < lim; j++) begin
				if (mirror_loaded[j] && !mirror_taken[j] && mirror_size[j] >= it.size) begin
					if (!found || mirror_size[j] < mirror_size[best]) begin
						best = j;
						found = 1'b1;
					end
				end
			end
			if (found) begin
				mirror_taken[best] = 1'b1;
				r.granted = 1'b1;
				r.chosen = best[PIDX_W-1:0];
				r.leftover = mirror_size[best] - it.size;
				mirror_internal = sat_sum(mirror_internal, r.leftover);
				grant_count++;
			end else begin
				mirror_external = sat_sum(mirror_external, it.size);
				refuse_count++;
			end
		end
		r.internal_total = mirror_internal;
		r.external_total = mirror_external;
		return r;
	endfunction

	// Sizes mostly small so that ties and close fits are common, sometimes wide or extreme.
	function automatic logic [SIZEP_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			6, 7: return SIZEP_W'($urandom_range(0, 4095));
			8: return SIZEP_W'($urandom);
			9: return $urandom_range(0, 1) ? {SIZEP_W{1'b1}} : '0;
			default: return SIZEP_W'($urandom_range(0, 63));
		endcase
	endfunction

	task automatic queue_item(input bfpa_pkg::op_t op, input logic [PIDX_W-1:0] part,
			input logic [SIZEP_W-1:0] size);
		alloc_item_t it;
		it.operation = op;
		it.part = part;
		it.size = size;
		pending_items.push_back(it);
		queued_count++;
	endtask

	// Holds the sender until every queued beat has been taken and answered.
	task automatic drain();
		while (accepted_count != queued_count || predicted_beats.size() != 0)
			@(posedge clk);
	endtask

	// Writes the search count over the configuration channel; the block must be idle.
	task automatic set_search_count(input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		mirror_count = value;
		cfg_valid <= 1'b0;
		cfg_data <= CFG_W'($urandom);
	endtask

	// Random phase: loads aimed mostly at searched partitions, requests of similar sizes.
	task automatic random_phase(input int count);
		int k;
		int reach;
		logic [PIDX_W-1:0] part;
		reach = (mirror_count > PARTITIONS_DEF) ? PARTITIONS_DEF : mirror_count;
		for (k = 0; k < count; k++) begin
			if (reach != 0 && $urandom_range(0, 3) != 0)
				part = PIDX_W'($urandom_range(0, reach - 1));
			else
				part = PIDX_W'($urandom);
			if ($urandom_range(0, 99) < 45)
				queue_item(bfpa_pkg::OP_LOAD, part, pick_size());
			else
				queue_item(bfpa_pkg::OP_REQUEST, PIDX_W'($urandom), pick_size());
		end
	endtask

	// Sender: bursts of beats separated by random gaps; a beat is taken when busy is low.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predicted_beats.push_back(predict_alloc(cur_item));
				accepted_count++;
			end
			if (!start || !busy) begin
				if (gap_left != 0 || pending_items.size() == 0) begin
					if (gap_left != 0)
						gap_left--;
					start <= 1'b0;
					operation <= 1'($urandom);
					partition_index <= PIDX_W'($urandom);
					size_value <= SIZEP_W'($urandom);
				end else begin
					cur_item = pending_items.pop_front();
					start <= 1'b1;
					operation <= cur_item.operation;
					partition_index <= cur_item.part;
					size_value <= cur_item.size;
					if (burst_left != 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 15);
						case ($urandom_range(0, 3))
							0: gap_left = 0;
							3: gap_left = $urandom_range(5, 25);
							default: gap_left = $urandom_range(1, 4);
						endcase
					end
				end
			end
		end
	end

	// Receiver: every done beat is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (predicted_beats.size() == 0) begin
				$error("result beat with no item outstanding");
				fail_count++;
			end else begin
				want = predicted_beats.pop_front();
				beat_count++;
				if (granted !== want.granted) begin
					$error("granted: expected %0d, got %0d", want.granted, granted);
					fail_count++;
				end
				if (chosen_partition !== want.chosen) begin
					$error("chosen_partition: expected %0d, got %0d",
						want.chosen, chosen_partition);
					fail_count++;
				end
				if (leftover !== want.leftover) begin
					$error("leftover: expected %0d, got %0d", want.leftover, leftover);
					fail_count++;
				end
				if (internal_total !== want.internal_total) begin
					$error("internal_total: expected %0d, got %0d",
						want.internal_total, internal_total);
					fail_count++;
				end
				if (external_total !== want.external_total) begin
					$error("external_total: expected %0d, got %0d",
						want.external_total, external_total);
					fail_count++;
				end
			end
		end
	end

	// Stimulus sequence.
	initial begin
		int i;
		int ph;
		logic [CFG_W-1:0] plan [7];
		for (i = 0; i < PARTITIONS_DEF; i++) begin
			mirror_size[i] = '0;
			mirror_loaded[i] = 1'b0;
			mirror_taken[i] = 1'b0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Nothing searched: every request fails, zero-size and full-size alike.
		set_search_count('0);
		queue_item(bfpa_pkg::OP_REQUEST, 4'hF, 16'd0);
		queue_item(bfpa_pkg::OP_REQUEST, 4'h0, 16'hFFFF);
		queue_item(bfpa_pkg::OP_LOAD, 4'h0, 16'd100);
		drain();

		// One partition: grant, refuse while occupied, reload over an occupied entry.
		set_search_count(5'd1);
		queue_item(bfpa_pkg::OP_REQUEST, 4'hF, 16'd50);
		queue_item(bfpa_pkg::OP_REQUEST, 4'h0, 16'd0);
		queue_item(bfpa_pkg::OP_LOAD, 4'h0, 16'd0);
		queue_item(bfpa_pkg::OP_REQUEST, 4'h5, 16'd0);
		queue_item(bfpa_pkg::OP_LOAD, 4'h0, 16'hFFFF);
		queue_item(bfpa_pkg::OP_REQUEST, 4'hA, 16'd0);
		drain();

		// Whole table loaded, then a search count above the table size.
		for (i = 0; i < PARTITIONS_DEF; i++)
			queue_item(bfpa_pkg::OP_LOAD, PIDX_W'(i), fill_sizes[i]);
		drain();
		set_search_count(5'd31);
		queue_item(bfpa_pkg::OP_REQUEST, 4'h0, 16'd400);
		queue_item(bfpa_pkg::OP_REQUEST, 4'hF, 16'd400);
		queue_item(bfpa_pkg::OP_LOAD, 4'h3, 16'd500);
		queue_item(bfpa_pkg::OP_REQUEST, 4'h7, 16'd450);
		queue_item(bfpa_pkg::OP_REQUEST, 4'h1, 16'hFFFF);
		queue_item(bfpa_pkg::OP_REQUEST, 4'h2, 16'hFFFF);
		drain();

		// Random phases over several search counts.
		plan = '{5'd16, 5'd3, 5'd31, 5'd0, 5'd1, 5'd8, 5'd20};
		plan[5] = CFG_W'($urandom_range(2, 15));
		plan[6] = CFG_W'($urandom_range(17, 30));
		for (ph = 0; ph < 7; ph++) begin
			set_search_count(plan[ph]);
			random_phase(118);
			drain();
		end

		// Settle time for any stray beat, then the verdict.
		repeat (24) @(posedge clk);
		$display("%0d beats checked: %0d loads, %0d grants, %0d refusals",
			beat_count, load_count, grant_count, refuse_count);
		$display("search counts from zero to past the table size, ties and reloads covered");
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#6000000;
		$display("simulation failed");
		$finish;
	end

endmodule
